[rtl/core/slotmp_pkg.sv]
// ----------------------------------------------------------------------------
// slotmp_pkg
// Shared types, codes and constants of the slot toolpath generator.
// ----------------------------------------------------------------------------
package slotmp_pkg;

  localparam int CoordW = 24;
  localparam int StepW  = 23;
  localparam int FeedW  = 20;
  localparam int CfgIdxW = 2;

  localparam int MAX_PASSES_DEF = 20;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [StepW-1:0]         step_t;
  typedef logic [FeedW-1:0]         feed_t;
  typedef logic [1:0]               kind_t;

  localparam kind_t KIND_RAPID  = 2'd0;
  localparam kind_t KIND_PLUNGE = 2'd1;
  localparam kind_t KIND_CUT    = 2'd2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SAFE_HEIGHT = 2'd0,
    CFG_DEPTH_STEP  = 2'd1,
    CFG_PLUNGE_FEED = 2'd2,
    CFG_CUT_FEED    = 2'd3
  } cfg_idx_t;

  localparam coord_t SAFE_HEIGHT_RST = 24'sd5000;
  localparam step_t  DEPTH_STEP_RST  = 23'd1000;
  localparam feed_t  PLUNGE_FEED_RST = 20'd100;
  localparam feed_t  CUT_FEED_RST    = 20'd500;

  typedef struct packed {
    coord_t slot_start_x;
    coord_t slot_start_y;
    coord_t slot_end_x;
    coord_t slot_end_y;
    coord_t final_depth;
  } in_item_t;

  typedef struct packed {
    kind_t  segment_kind;
    coord_t from_x;
    coord_t from_y;
    coord_t from_z;
    coord_t to_x;
    coord_t to_y;
    coord_t to_z;
    feed_t  feed_rate;
    logic   last_segment;
    logic   pass_overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_PLUNGE,
    ST_CUT,
    ST_RETRACT,
    ST_FINAL
  } fsm_state_t;

  typedef enum logic [2:0] {
    SEG_FIRST,
    SEG_PLUNGE,
    SEG_CUT,
    SEG_RETRACT,
    SEG_FINAL
  } seg_sel_t;

  typedef struct packed {
    logic     capture;
    logic     load;
    seg_sel_t seg;
  } ctrl_cmd_t;

  typedef struct packed {
    logic go_now;
    logic go_after;
  } dp_status_t;

endpackage

[rtl/core/slotmp_ctrl.sv]
// ----------------------------------------------------------------------------
// slotmp_ctrl
// Segment sequencer: steps through rapid, plunge, cut and retract segments
// and owns the output valid flag.
// ----------------------------------------------------------------------------
module slotmp_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  slotmp_pkg::dp_status_t status,
  output slotmp_pkg::ctrl_cmd_t  cmd
);
  import slotmp_pkg::*;

  fsm_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       adv;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_FIRST;
      ST_FIRST:   if (adv) state_nxt = status.go_now ? ST_PLUNGE : ST_FINAL;
      ST_PLUNGE:  if (adv) state_nxt = ST_CUT;
      ST_CUT:     if (adv) state_nxt = ST_RETRACT;
      ST_RETRACT: if (adv) state_nxt = status.go_after ? ST_PLUNGE : ST_FINAL;
      ST_FINAL:   if (adv) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.capture = (state_r == ST_IDLE) && in_valid;
    cmd.load    = (state_r != ST_IDLE) && adv;
    unique case (state_r)
      ST_FIRST:   cmd.seg = SEG_FIRST;
      ST_PLUNGE:  cmd.seg = SEG_PLUNGE;
      ST_CUT:     cmd.seg = SEG_CUT;
      ST_RETRACT: cmd.seg = SEG_RETRACT;
      ST_FINAL:   cmd.seg = SEG_FINAL;
      default:    cmd.seg = SEG_FIRST;
    endcase
  end

  always_comb begin
    priority if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_valid_r)
    else $error("loaded segment not presented");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && out_valid_r && out_stall) |=> $stable(state_r))
    else $error("sequencer advanced under output stall");

  a_final_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINAL && adv) |=> (state_r == ST_IDLE && out_valid_r))
    else $error("final segment did not close the command");

endmodule

[rtl/core/slotmp_dp.sv]
// ----------------------------------------------------------------------------
// slotmp_dp
// Datapath: configuration registers, command latch, pass depth tracking
// and the output segment register.
// ----------------------------------------------------------------------------
module slotmp_dp #(
  parameter int MaxPasses = slotmp_pkg::MAX_PASSES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [slotmp_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [slotmp_pkg::CoordW-1:0]  cfg_data,
  input  slotmp_pkg::in_item_t   in_data,
  input  slotmp_pkg::ctrl_cmd_t  cmd,
  output slotmp_pkg::dp_status_t status,
  output slotmp_pkg::out_item_t  out_data
);
  import slotmp_pkg::*;

  localparam int CntW = $clog2(MaxPasses + 1);
  localparam logic [CntW-1:0] CntMax  = CntW'(MaxPasses);
  localparam logic [CntW-1:0] CntLast = CntW'(MaxPasses - 1);

  coord_t safe_height_r;
  step_t  depth_step_r;
  feed_t  plunge_feed_r;
  feed_t  cut_feed_r;

  in_item_t        cmd_r;
  coord_t          cur_r;
  coord_t          nz_r;
  logic            fwd_r;
  logic [CntW-1:0] pass_cnt_r;
  out_item_t       out_r, seg_nxt;

  logic signed [CoordW:0] diff;
  logic signed [CoordW:0] tgt_ext;
  coord_t nz_calc;
  coord_t fx, fy, tx, ty, lx, ly;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      safe_height_r <= SAFE_HEIGHT_RST;
      depth_step_r  <= DEPTH_STEP_RST;
      plunge_feed_r <= PLUNGE_FEED_RST;
      cut_feed_r    <= CUT_FEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SAFE_HEIGHT: safe_height_r <= cfg_data;
        CFG_DEPTH_STEP:  depth_step_r  <= cfg_data[StepW-1:0];
        CFG_PLUNGE_FEED: plunge_feed_r <= cfg_data[FeedW-1:0];
        CFG_CUT_FEED:    cut_feed_r    <= cfg_data[FeedW-1:0];
        default: ;
      endcase
    end
  end

  assign tgt_ext = {cmd_r.final_depth[CoordW-1], cmd_r.final_depth};
  assign diff    = {cur_r[CoordW-1], cur_r} - {2'b00, depth_step_r};
  assign nz_calc = (diff < tgt_ext) ? cmd_r.final_depth : diff[CoordW-1:0];

  assign fx = fwd_r ? cmd_r.slot_start_x : cmd_r.slot_end_x;
  assign fy = fwd_r ? cmd_r.slot_start_y : cmd_r.slot_end_y;
  assign tx = fwd_r ? cmd_r.slot_end_x   : cmd_r.slot_start_x;
  assign ty = fwd_r ? cmd_r.slot_end_y   : cmd_r.slot_start_y;
  assign lx = fx;
  assign ly = fy;

  assign status.go_now   = (cur_r > cmd_r.final_depth) && (pass_cnt_r < CntMax);
  assign status.go_after = (nz_r > cmd_r.final_depth) && (pass_cnt_r < CntLast);

  always_comb begin
    seg_nxt = '0;
    unique case (cmd.seg)
      SEG_FIRST: begin
        seg_nxt.segment_kind = KIND_RAPID;
        seg_nxt.from_z       = safe_height_r;
        seg_nxt.to_x         = cmd_r.slot_start_x;
        seg_nxt.to_y         = cmd_r.slot_start_y;
        seg_nxt.to_z         = safe_height_r;
      end
      SEG_PLUNGE: begin
        seg_nxt.segment_kind = KIND_PLUNGE;
        seg_nxt.from_x       = fx;
        seg_nxt.from_y       = fy;
        seg_nxt.from_z       = safe_height_r;
        seg_nxt.to_x         = fx;
        seg_nxt.to_y         = fy;
        seg_nxt.to_z         = nz_calc;
        seg_nxt.feed_rate    = plunge_feed_r;
      end
      SEG_CUT: begin
        seg_nxt.segment_kind = KIND_CUT;
        seg_nxt.from_x       = fx;
        seg_nxt.from_y       = fy;
        seg_nxt.from_z       = nz_r;
        seg_nxt.to_x         = tx;
        seg_nxt.to_y         = ty;
        seg_nxt.to_z         = nz_r;
        seg_nxt.feed_rate    = cut_feed_r;
      end
      SEG_RETRACT: begin
        seg_nxt.segment_kind = KIND_RAPID;
        seg_nxt.from_x       = tx;
        seg_nxt.from_y       = ty;
        seg_nxt.from_z       = nz_r;
        seg_nxt.to_x         = tx;
        seg_nxt.to_y         = ty;
        seg_nxt.to_z         = safe_height_r;
      end
      SEG_FINAL: begin
        seg_nxt.segment_kind  = KIND_RAPID;
        seg_nxt.from_x        = lx;
        seg_nxt.from_y        = ly;
        seg_nxt.from_z        = safe_height_r;
        seg_nxt.to_x          = cmd_r.slot_start_x;
        seg_nxt.to_y          = cmd_r.slot_start_y;
        seg_nxt.to_z          = safe_height_r;
        seg_nxt.last_segment  = 1'b1;
        seg_nxt.pass_overflow = (cur_r > cmd_r.final_depth);
      end
      default: seg_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r      <= in_data;
      cur_r      <= '0;
      fwd_r      <= 1'b1;
      pass_cnt_r <= '0;
    end else if (cmd.load) begin
      if (cmd.seg == SEG_PLUNGE) begin
        nz_r <= nz_calc;
      end
      if (cmd.seg == SEG_RETRACT) begin
        cur_r      <= nz_r;
        fwd_r      <= !fwd_r;
        pass_cnt_r <= pass_cnt_r + 1'b1;
      end
    end
    if (cmd.load) begin
      out_r <= seg_nxt;
    end
  end

  assign out_data = out_r;

endmodule

[rtl/core/slot_multipass_toolpath_gen_unit.sv]
// ----------------------------------------------------------------------------
// slot_multipass_toolpath_gen_unit
// Multi-pass zigzag slot milling toolpath generator, top level.
// ----------------------------------------------------------------------------
// One command is taken at a time. It yields 2 + 3*P segments, P being the
// number of passes (at most MAX_PASSES), and the sequencer produces one
// segment per cycle into a single output register unless the output stalls;
// the command itself is captured before its first segment is loaded. The
// next command is accepted as soon as the final segment has been loaded,
// while that segment may still wait on the output. Configuration writes are
// taken every cycle and should only be made while no command is in flight.
module slot_multipass_toolpath_gen_unit #(
  parameter int MAX_PASSES = slotmp_pkg::MAX_PASSES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  slotmp_pkg::in_item_t           in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output slotmp_pkg::out_item_t          out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [slotmp_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [slotmp_pkg::CoordW-1:0]  cfg_data
);
  import slotmp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  slotmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  slotmp_dp #(
    .MaxPasses (MAX_PASSES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule
